// ===== sv/qri_pkg.sv =====
`default_nettype none
package qri_pkg;
	localparam int QUAT_FRAC_BITS = 30;
	localparam int RATE_FRAC_BITS = 16;
	localparam int HALF_FRAC = 24;
	localparam int HALF_SHIFT = RATE_FRAC_BITS + 25 - HALF_FRAC;
	localparam logic [23:0] DT_RESET = 24'd167772;
	localparam logic [30:0] TOL_RESET = 31'd107374;
	localparam logic [31:0] QUAT_ONE = 32'sd1 <<< QUAT_FRAC_BITS;

	localparam logic CMD_INTEGRATE = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic CFG_TIME_STEP = 1'b0;
	localparam logic CFG_NORM_TOL = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RENORM = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef logic signed [31:0] comp_t;
	typedef comp_t [3:0] quat_t;

	// multiply-accumulate command from the sequencer to the shared unit
	typedef struct packed {
		logic clr;
		logic en;
		logic neg;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mac_cmd_t;
endpackage
`default_nettype wire

// ===== sv/qri_mac.sv =====
`default_nettype none
// shared 32x32 signed multiply with 72-bit accumulator, product registered
module qri_mac (
	input wire logic clk,
	input wire logic arst_n,
	input wire qri_pkg::mac_cmd_t cmd,
	output logic signed [71:0] acc
);
	logic signed [63:0] prod_s1;
	logic vld_s1, neg_s1, clr_s1;
	logic signed [71:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			clr_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			vld_s1 <= cmd.en;
			clr_s1 <= cmd.clr;
			neg_s1 <= cmd.neg;
			if (clr_s1)
				acc_q <= '0;
			else if (vld_s1)
				acc_q <= neg_s1 ? acc_q - 72'(prod_s1) : acc_q + 72'(prod_s1);
		end
	end

	always_ff @(posedge clk)
		prod_s1 <= cmd.a * cmd.b;

	assign acc = acc_q;
endmodule
`default_nettype wire

// ===== sv/qri_div.sv =====
`default_nettype none
// restoring divider and square root, one result bit per cycle
module qri_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start_div,
	input wire logic start_sqrt,
	input wire logic [63:0] num,
	input wire logic [32:0] den,
	output logic busy,
	output logic [63:0] result
);
	logic [6:0] cnt_q;
	logic mode_q;
	logic [63:0] rem_q, quo_q, val_q;
	logic [32:0] den_q;
	logic [64:0] trial;
	logic [65:0] sq_rem;
	logic [65:0] sq_trial;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		sq_rem = {rem_q[63:0], val_q[63:62]};
		sq_trial = {quo_q[63:0], 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mode_q <= 1'b0;
		end else if (start_div || start_sqrt) begin
			cnt_q <= start_div ? 7'd64 : 7'd32;
			mode_q <= start_sqrt;
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (start_sqrt) begin
			rem_q <= '0;
			quo_q <= '0;
			val_q <= num;
		end else if (cnt_q != 0) begin
			if (!mode_q) begin
				if (trial >= 65'(den_q)) begin
					rem_q <= 64'(trial - 65'(den_q));
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				val_q <= {val_q[61:0], 2'b00};
				if (sq_rem >= sq_trial) begin
					rem_q <= 64'(sq_rem - sq_trial);
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= sq_rem[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	assign busy = (cnt_q != 0);
	assign result = quo_q;
endmodule
`default_nettype wire

// ===== sv/quaternion_rate_integrator_unit.sv =====
// an integrate inside the tolerance band computes three half angles, four omega rows and
// the norm, a load goes straight to the norm; renormalizing adds a square root and four divides
// throughput: one request at a time, ready for the next in the cycle after the result is
// registered; the shared multiplier and the serial divider set the pace
// a finished result waits in the output register while the next request enters
// reset: quaternion (1,0,0,0), time_step 167772, norm_tolerance 107374
`default_nettype none
module quaternion_rate_integrator_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// roll_rate, pitch_rate, yaw_rate, load_w, load_x, load_y, load_z
	input wire logic [199:0] s_axis_tdata,
	// cmd
	input wire logic s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// out_w, out_x, out_y, out_z, norm_status, pad
	output logic [135:0] m_axis_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam logic [3:0] S_IDLE = 4'd0, S_HALF = 4'd1, S_HWAIT = 4'd2, S_ROW = 4'd3,
		S_RWAIT = 4'd4, S_NORM = 4'd5, S_NWAIT = 4'd6, S_CHECK = 4'd7, S_SQRT = 4'd8,
		S_DIV = 4'd9, S_DWAIT = 4'd10, S_DONE = 4'd11, S_OUT = 4'd12;

	logic [3:0] state_q;
	logic [23:0] dt_q;
	logic [30:0] tol_q;
	qri_pkg::quat_t quat_q, c_q;
	logic signed [31:0] h_q [3];
	logic signed [23:0] rate_q [3];
	logic [2:0] idx_q;
	logic [1:0] sub_q;
	logic [2:0] wait_q;
	logic sat_q;
	logic [1:0] status_q;
	logic [63:0] norm_q;
	logic [32:0] s_q;
	logic [135:0] out_q;
	logic out_vld_q;

	qri_pkg::mac_cmd_t mc;
	logic signed [71:0] acc;
	logic dv_start, sq_start, dv_busy;
	logic [63:0] dv_num, dv_res;

	qri_mac u_mac (.clk(clk), .arst_n(arst_n), .cmd(mc), .acc(acc));
	qri_div u_div (.clk(clk), .arst_n(arst_n), .start_div(dv_start), .start_sqrt(sq_start),
		.num(dv_num), .den(s_q), .busy(dv_busy), .result(dv_res));

	// omega row terms: component index and rate index and sign per row and term
	logic [1:0] row_c, row_h;
	logic row_neg;
	always_comb begin
		row_c = 2'd0; row_h = 2'd0; row_neg = 1'b0;
		case ({idx_q[1:0], sub_q})
			4'b00_00: begin row_c = 2'd1; row_h = 2'd0; row_neg = 1'b1; end
			4'b00_01: begin row_c = 2'd2; row_h = 2'd1; row_neg = 1'b1; end
			4'b00_10: begin row_c = 2'd3; row_h = 2'd2; row_neg = 1'b1; end
			4'b01_00: begin row_c = 2'd0; row_h = 2'd0; end
			4'b01_01: begin row_c = 2'd2; row_h = 2'd2; end
			4'b01_10: begin row_c = 2'd3; row_h = 2'd1; row_neg = 1'b1; end
			4'b10_00: begin row_c = 2'd0; row_h = 2'd1; end
			4'b10_01: begin row_c = 2'd1; row_h = 2'd2; row_neg = 1'b1; end
			4'b10_10: begin row_c = 2'd3; row_h = 2'd0; end
			4'b11_00: begin row_c = 2'd0; row_h = 2'd2; end
			4'b11_01: begin row_c = 2'd1; row_h = 2'd1; end
			4'b11_10: begin row_c = 2'd2; row_h = 2'd0; row_neg = 1'b1; end
			default: ;
		endcase
	end

	always_comb begin
		mc = '0;
		case (state_q)
			S_HALF: begin
				mc.en = 1'b1;
				mc.a = 32'(rate_q[idx_q[1:0]]);
				mc.b = $signed({8'd0, dt_q});
			end
			S_ROW: begin
				mc.en = 1'b1;
				mc.neg = row_neg;
				mc.a = quat_q[row_c];
				mc.b = h_q[row_h];
			end
			S_NORM: begin
				mc.en = 1'b1;
				mc.a = c_q[idx_q[1:0]];
				mc.b = c_q[idx_q[1:0]];
			end
			default: ;
		endcase
		// accumulator starts empty for every request and before each half angle, row and the norm
		if (state_q == S_IDLE
			|| ((state_q == S_HWAIT || state_q == S_RWAIT) && wait_q == 3'd0))
			mc.clr = 1'b1;
	end

	// rounded half angle and rounded increment from the accumulator
	logic signed [71:0] h_rnd, d_rnd, cur_sum;
	logic signed [71:0] h_sat;
	always_comb begin
		h_rnd = (acc + (72'sd1 <<< (qri_pkg::HALF_SHIFT - 1))) >>> qri_pkg::HALF_SHIFT;
		if (h_rnd > 72'sd1073741824) h_sat = 72'sd1073741824;
		else if (h_rnd < -72'sd1073741824) h_sat = -72'sd1073741824;
		else h_sat = h_rnd;
		d_rnd = (acc + (72'sd1 <<< (qri_pkg::HALF_FRAC - 1))) >>> qri_pkg::HALF_FRAC;
		cur_sum = 72'(quat_q[idx_q[1:0]]) + d_rnd;
	end

	// tolerance band
	logic [63:0] one_w, tol_w, lo_w, hi_w;
	always_comb begin
		one_w = 64'd1 << (2 * qri_pkg::QUAT_FRAC_BITS);
		tol_w = 64'(tol_q) << qri_pkg::QUAT_FRAC_BITS;
		lo_w = (tol_w >= one_w) ? 64'd0 : one_w - tol_w;
		hi_w = one_w + tol_w;
	end

	// component magnitude scaled up for the divide, rounding half folded in
	logic signed [31:0] cur_c;
	logic [32:0] cur_mag;
	logic [64:0] q_mag;
	logic signed [65:0] q_signed;
	always_comb begin
		cur_c = c_q[idx_q[1:0]];
		cur_mag = cur_c[31] ? 33'd0 - 33'(cur_c) : {1'b0, cur_c};
		// square root takes the norm, divides take the scaled component
		if (state_q == S_CHECK)
			dv_num = norm_q;
		else
			dv_num = (64'(cur_mag) << qri_pkg::QUAT_FRAC_BITS) + 64'(s_q >> 1);
		q_mag = {1'b0, dv_res};
		q_signed = cur_c[31] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	end

	assign dv_start = (state_q == S_DIV);
	assign sq_start = (state_q == S_CHECK) && !(norm_q >= lo_w && norm_q <= hi_w)
		&& norm_q != 0;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dt_q <= qri_pkg::DT_RESET;
			tol_q <= qri_pkg::TOL_RESET;
			quat_q[0] <= qri_pkg::QUAT_ONE;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
			out_vld_q <= 1'b0;
			idx_q <= '0;
			sub_q <= '0;
			wait_q <= '0;
		end else begin
			if (state_q == S_OUT && (!out_vld_q || m_axis_tready))
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == qri_pkg::CFG_TIME_STEP) dt_q <= cfg_data[23:0];
				else tol_q <= cfg_data[30:0];
			end
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					idx_q <= '0;
					sub_q <= '0;
					wait_q <= 3'd2;
					state_q <= (s_axis_tuser == qri_pkg::CMD_LOAD) ? S_NORM : S_HALF;
				end
				S_HALF: begin
					wait_q <= 3'd2;
					state_q <= S_HWAIT;
				end
				S_HWAIT: if (wait_q != 0) wait_q <= wait_q - 3'd1;
					else begin
						if (idx_q == 3'd2) begin
							idx_q <= '0;
							state_q <= S_ROW;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= S_HALF;
						end
					end
				S_ROW: if (sub_q == 2'd2) begin
					sub_q <= '0;
					wait_q <= 3'd2;
					state_q <= S_RWAIT;
				end else sub_q <= sub_q + 2'd1;
				S_RWAIT: if (wait_q != 0) wait_q <= wait_q - 3'd1;
					else begin
						if (idx_q == 3'd3) begin
							idx_q <= '0;
							state_q <= S_NORM;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= S_ROW;
						end
					end
				S_NORM: if (idx_q == 3'd3) begin
					wait_q <= 3'd3;
					state_q <= S_NWAIT;
				end else idx_q <= idx_q + 3'd1;
				S_NWAIT: if (wait_q != 0) wait_q <= wait_q - 3'd1;
					else state_q <= S_CHECK;
				S_CHECK: begin
					idx_q <= '0;
					if (norm_q == 0) state_q <= S_DONE;
					else if (norm_q >= lo_w && norm_q <= hi_w) state_q <= S_DONE;
					else state_q <= S_SQRT;
				end
				S_SQRT: if (!dv_busy && wait_q == 0) state_q <= S_DIV;
					else wait_q <= '0;
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: if (!dv_busy) begin
					if (idx_q == 3'd3) state_q <= S_DONE;
					else begin
						idx_q <= idx_q + 3'd1;
						state_q <= S_DIV;
					end
				end
				S_DONE: state_q <= S_OUT;
				S_OUT: if (!out_vld_q || m_axis_tready)
					state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DONE && status_q != qri_pkg::ST_ZERO)
				quat_q <= c_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				sat_q <= 1'b0;
				norm_q <= '0;
				rate_q[0] <= s_axis_tdata[23:0];
				rate_q[1] <= s_axis_tdata[47:24];
				rate_q[2] <= s_axis_tdata[71:48];
				c_q[0] <= s_axis_tdata[103:72];
				c_q[1] <= s_axis_tdata[135:104];
				c_q[2] <= s_axis_tdata[167:136];
				c_q[3] <= s_axis_tdata[199:168];
			end
			S_HWAIT: if (wait_q == 0) h_q[idx_q[1:0]] <= h_sat[31:0];
			S_RWAIT: if (wait_q == 0) begin
				if (cur_sum > 72'sd2147483647) begin
					c_q[idx_q[1:0]] <= 32'h7fffffff;
					sat_q <= 1'b1;
				end else if (cur_sum < -72'sd2147483648) begin
					c_q[idx_q[1:0]] <= 32'h80000000;
					sat_q <= 1'b1;
				end else c_q[idx_q[1:0]] <= cur_sum[31:0];
			end
			// four full-scale squares reach 2^64, held at the top of 64 bits
			S_NWAIT: if (wait_q == 0)
				norm_q <= (acc[71:64] != 8'd0) ? '1 : acc[63:0];
			S_CHECK: begin
				if (norm_q == 0) status_q <= qri_pkg::ST_ZERO;
				else if (norm_q >= lo_w && norm_q <= hi_w)
					status_q <= sat_q ? qri_pkg::ST_SAT : qri_pkg::ST_OK;
				else status_q <= qri_pkg::ST_RENORM;
			end
			S_SQRT: if (!dv_busy && wait_q == 0) s_q <= {1'b0, dv_res[31:0]};
			S_DWAIT: if (!dv_busy) begin
				if (q_signed > 66'sd2147483647) begin
					c_q[idx_q[1:0]] <= 32'h7fffffff;
					status_q <= qri_pkg::ST_SAT;
				end else if (q_signed < -66'sd2147483648) begin
					c_q[idx_q[1:0]] <= 32'h80000000;
					status_q <= qri_pkg::ST_SAT;
				end else c_q[idx_q[1:0]] <= q_signed[31:0];
				if (sat_q) status_q <= qri_pkg::ST_SAT;
			end
			// stored quaternion is the old one on zero norm, the new one otherwise
			S_OUT: if (!out_vld_q || m_axis_tready)
				out_q <= {6'd0, status_q, quat_q[3], quat_q[2], quat_q[1], quat_q[0]};
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_zero_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == qri_pkg::ST_ZERO) |=> $stable(quat_q))
		else $error("zero norm changed state");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_busy) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ===== dv/qri_checker.sv =====
`default_nettype none
module qri_checker
	import qri_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [199:0] s_axis_tdata,
	input wire logic s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [135:0] m_axis_tdata,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	output int errors,
	output int pending
);
	logic [23:0] dt;
	logic [30:0] tol;
	logic signed [31:0] qw, qx, qy, qz;
	logic [129:0] attitude_q[$];

	assign pending = attitude_q.size();

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic longint half_ang(logic signed [23:0] r);
		longint p, h;
		p = longint'(r) * longint'({1'b0, dt});
		h = rnd_shift(p, HALF_SHIFT);
		if (h > 64'sd1073741824) h = 64'sd1073741824;
		if (h < -64'sd1073741824) h = -64'sd1073741824;
		return h;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] rescale(logic signed [31:0] c, logic [63:0] s,
			inout bit sat);
		logic [63:0] mag, q;
		longint v;
		mag = c < 0 ? -{{32{c[31]}}, c} : {32'd0, c};
		q = ((mag << QUAT_FRAC_BITS) + s / 2) / s;
		v = q;
		return clamp32(c < 0 ? -v : v, sat);
	endfunction

	// advances or loads the attitude (kept on zero norm) and returns {status,z,y,x,w}
	function automatic logic [129:0] attitude_step(logic cmd, logic [199:0] d);
		logic signed [31:0] c[4];
		longint h1, h2, h3, w, x, y, z, d0, d1, d2, d3;
		logic [63:0] nrm, sq, one, tl, lo, hi, s;
		bit sat;
		logic [1:0] st;
		sat = 0;
		if (cmd == CMD_LOAD) begin
			for (int i = 0; i < 4; i++) c[i] = d[72 + 32*i +: 32];
		end else begin
			h1 = half_ang(d[23:0]);
			h2 = half_ang(d[47:24]);
			h3 = half_ang(d[71:48]);
			w = qw; x = qx; y = qy; z = qz;
			d0 = -x*h1 - y*h2 - z*h3;
			d1 = w*h1 + y*h3 - z*h2;
			d2 = w*h2 - x*h3 + z*h1;
			d3 = w*h3 + x*h2 - y*h1;
			c[0] = clamp32(w + rnd_shift(d0, HALF_FRAC), sat);
			c[1] = clamp32(x + rnd_shift(d1, HALF_FRAC), sat);
			c[2] = clamp32(y + rnd_shift(d2, HALF_FRAC), sat);
			c[3] = clamp32(z + rnd_shift(d3, HALF_FRAC), sat);
		end
		nrm = 0;
		for (int i = 0; i < 4; i++) begin
			sq = longint'(c[i]) * longint'(c[i]);
			if (nrm > ~64'd0 - sq) nrm = ~64'd0;
			else nrm += sq;
		end
		if (nrm == 0) begin
			st = ST_ZERO;
		end else begin
			one = 64'd1 << (2*QUAT_FRAC_BITS);
			tl = {33'd0, tol} << QUAT_FRAC_BITS;
			lo = tl >= one ? 64'd0 : one - tl;
			hi = one + tl;
			st = ST_OK;
			if (nrm < lo || nrm > hi) begin
				s = root64(nrm);
				for (int i = 0; i < 4; i++) c[i] = rescale(c[i], s, sat);
				st = ST_RENORM;
			end
			if (sat) st = ST_SAT;
			qw = c[0]; qx = c[1]; qy = c[2]; qz = c[3];
		end
		return {st, qz, qy, qx, qw};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [129:0] e;
		if (!arst_n) begin
			dt <= DT_RESET;
			tol <= TOL_RESET;
			qw = QUAT_ONE; qx = 0; qy = 0; qz = 0;
			errors <= 0;
			attitude_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TIME_STEP) dt <= cfg_data[23:0];
				else tol <= cfg_data[30:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				attitude_q.push_back(attitude_step(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (attitude_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					errors <= errors + 1;
				end else begin
					e = attitude_q.pop_front();
					if (m_axis_tdata[129:0] !== e) begin
						$display("%0t: mismatch expected %h actual %h", $time, e,
							m_axis_tdata[129:0]);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
	import qri_pkg::*;
	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [199:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [135:0] m_axis_tdata;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [31:0] cfg_data;
	int errors, pending;
	longint cycles;
	bit calm;

	quaternion_rate_integrator_unit dut (.*);
	qri_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("quaternion_rate_integrator_unit verification failed");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 15);
			m_axis_tready <= calm || $urandom_range(0, 2) != 0;
			repeat (n) @(posedge clk);
		end
	end

	task automatic write_reg(logic idx, logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic send_request(logic cmd, logic [199:0] d);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [31:0] rcomp();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 0;
			3: return $urandom_range(0, 1) ? QUAT_ONE : -QUAT_ONE;
			4: return $urandom();
			default: return $signed($urandom_range(0, 1 << 29)) - (1 << 28);
		endcase
	endfunction

	function automatic logic [23:0] rrate();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'($urandom());
			default: return 24'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
		endcase
	endfunction

	function automatic logic [199:0] rdata();
		return {rcomp(), rcomp(), rcomp(), rcomp(), rrate(), rrate(), rrate()};
	endfunction

	initial begin
		logic [31:0] q;
		s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		cycles = 0; calm = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: integrate extremes, loads with zero, saturation, renorm
		send_request(CMD_INTEGRATE, '0);
		send_request(CMD_INTEGRATE, {128'd0, 24'h7fffff, 24'h800000, 24'h7fffff});
		send_request(CMD_INTEGRATE, {128'd0, 24'h800000, 24'h7fffff, 24'h800000});
		send_request(CMD_LOAD, '0);
		send_request(CMD_LOAD, {32'd0, 32'd0, 32'd0, 32'h80000000, 72'hffffff});
		send_request(CMD_LOAD, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 72'd0});
		send_request(CMD_LOAD, {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			72'd0});
		send_request(CMD_LOAD, {96'd0, QUAT_ONE, 72'd0});
		send_request(CMD_INTEGRATE, {128'hffffffff_ffffffff_ffffffff_ffffffff, 72'h10000});
		send_request(CMD_INTEGRATE, {128'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff});
		drain();
		// sender holds off until every result is back
		write_reg(CFG_TIME_STEP, 32'h00ffffff);
		write_reg(CFG_NORM_TOL, 32'd0);
		send_request(CMD_INTEGRATE, {128'd0, 24'h7fffff, 24'h0, 24'h800000});
		send_request(CMD_LOAD, {32'h0, 32'h0, 32'h0, 32'h40000001, 72'd0});
		drain();
		write_reg(CFG_TIME_STEP, 32'd0);
		write_reg(CFG_NORM_TOL, 32'h40000000);
		send_request(CMD_INTEGRATE, {128'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff});
		send_request(CMD_LOAD, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 72'd0});
		send_request(CMD_LOAD, {32'd1, 32'd0, 32'd0, 32'd0, 72'd0});
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(CFG_TIME_STEP, phase == 5 ? 32'd167772 : $urandom_range(0, 24'hffffff));
			q = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31'h40000000)
				: $urandom_range(0, 200000);
			write_reg(CFG_NORM_TOL, q);
			if (phase == 5) calm = 1;
			for (int i = 0; i < 150; i++)
				send_request($urandom_range(0, 4) == 0, rdata());
			drain();
		end
		if (errors == 0) begin
			$display("quaternion_rate_integrator_unit verification clean");
		end else begin
			$display("quaternion_rate_integrator_unit verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== quaternion_rate_integrator_unit.f =====
sv/qri_pkg.sv
sv/qri_mac.sv
sv/qri_div.sv
sv/quaternion_rate_integrator_unit.sv
dv/qri_checker.sv
dv/tb.sv
